@@ rtl/ftlb_pkg.sv @@
// Package for the FIFO-replacement TLB: field widths, bit positions and the
// request codes. No dependencies.
`default_nettype none

package ftlb_pkg;

    localparam int ADDR_W   = 32;
    localparam int PAGE_W   = 20;
    localparam int PAGE_LSB = 12;
    localparam int FRAME_W  = 20;
    localparam int TOTAL_W  = 32;
    localparam int OCC_W    = 4;

    // Stored entry: page tag in the low bits, frame above it.
    localparam int ENTRY_W  = PAGE_W + FRAME_W;

    // Slave tdata: virt_addr, frame_in, zero pad to 56 bits.
    localparam int S_DATA_W = 56;
    // Master tdata: frame_out, hit_count, lookup_count, occupancy (88 bits).
    localparam int M_DATA_W = FRAME_W + TOTAL_W + TOTAL_W + OCC_W;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    typedef logic [PAGE_W-1:0]  t_page;
    typedef logic [FRAME_W-1:0] t_frame;
    typedef logic [TOTAL_W-1:0] t_total;

endpackage

`default_nettype wire

@@ rtl/ftlb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ftlb_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 8,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

@@ rtl/fifo_tlb_lookup_insert.sv @@
// Fully associative TLB with FIFO replacement, entries kept in a ring buffer RAM.
// An insert's result is valid in the cycle after its transfer. A lookup scans one entry per
// cycle, oldest first, and reports the oldest matching entry, or a miss once every entry is read.
// One item at a time: the next transfer is taken in the cycle its result transfers,
// so a held result stalls the input. Reset (i_rst_n low, synchronous) empties the table
// and clears both counters. Depends on ftlb_pkg and ftlb_ram.
`default_nettype none

module fifo_tlb_lookup_insert #(
    parameter int ENTRIES = 8
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // [31:0] virt_addr, [51:32] frame_in, [55:52] zero
    input  wire logic [ftlb_pkg::S_DATA_W-1:0]  i_s_tdata,
    // [0] req_type
    input  wire logic                           i_s_tuser,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // [19:0] frame_out, [51:20] hit_count, [83:52] lookup_count, [87:84] occupancy
    output logic      [ftlb_pkg::M_DATA_W-1:0]  o_m_tdata,
    // [0] hit
    output logic                                o_m_tuser
);

    localparam int PTR_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SCAN = 1'b1;

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        wrap_inc = (p == PTR_W'(ENTRIES - 1)) ? '0 : p + 1'b1;
    endfunction

    logic                  r_state, n_state;
    logic [PTR_W-1:0]      r_head, n_head;
    logic [PTR_W-1:0]      r_tail, n_tail;
    logic [PTR_W-1:0]      r_ptr, n_ptr;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_left, n_left;
    ftlb_pkg::t_total      r_hit_total, n_hit_total;
    ftlb_pkg::t_total      r_lookup_total, n_lookup_total;
    ftlb_pkg::t_page       r_page, n_page;
    logic                  r_m_valid, n_m_valid;
    logic                  r_m_hit, n_m_hit;
    ftlb_pkg::t_frame      r_m_frame, n_m_frame;

    logic                             s_accept;
    ftlb_pkg::t_page                  in_page;
    ftlb_pkg::t_frame                 in_frame;
    logic                             wr_en;
    logic [PTR_W-1:0]                 rd_addr;
    logic [ftlb_pkg::ENTRY_W-1:0]     rd_data;
    logic                             tag_match;

    assign o_s_tready = (r_state == ST_IDLE) && (!r_m_valid || i_m_tready);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign in_page    = i_s_tdata[ftlb_pkg::ADDR_W-1:ftlb_pkg::PAGE_LSB];
    assign in_frame   = i_s_tdata[ftlb_pkg::ADDR_W +: ftlb_pkg::FRAME_W];
    assign wr_en      = s_accept && (i_s_tuser == ftlb_pkg::REQ_INSERT);
    assign rd_addr    = (r_state == ST_IDLE) ? r_head : r_ptr;
    assign tag_match  = (rd_data[ftlb_pkg::PAGE_W-1:0] == r_page);

    ftlb_ram #(
        .WIDTH (ftlb_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_tail),
        .i_wr_data ({in_frame, in_page}),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_state        = r_state;
        n_head         = r_head;
        n_tail         = r_tail;
        n_ptr          = r_ptr;
        n_count        = r_count;
        n_left         = r_left;
        n_hit_total    = r_hit_total;
        n_lookup_total = r_lookup_total;
        n_page         = r_page;
        n_m_valid      = r_m_valid && !i_m_tready;
        n_m_hit        = r_m_hit;
        n_m_frame      = r_m_frame;

        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    if (i_s_tuser == ftlb_pkg::REQ_INSERT) begin
                        n_tail = wrap_inc(r_tail);
                        if (r_count == CNT_W'(ENTRIES)) begin
                            n_head = wrap_inc(r_head);
                        end else begin
                            n_count = r_count + 1'b1;
                        end
                        n_m_valid = 1'b1;
                        n_m_hit   = 1'b0;
                        n_m_frame = '0;
                    end else begin
                        n_lookup_total = r_lookup_total + 1'b1;
                        n_page         = in_page;
                        if (r_count == '0) begin
                            n_m_valid = 1'b1;
                            n_m_hit   = 1'b0;
                            n_m_frame = '0;
                        end else begin
                            n_ptr   = wrap_inc(r_head);
                            n_left  = r_count - 1'b1;
                            n_state = ST_SCAN;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (tag_match) begin
                    n_hit_total = r_hit_total + 1'b1;
                    n_m_valid   = 1'b1;
                    n_m_hit     = 1'b1;
                    n_m_frame   = rd_data[ftlb_pkg::ENTRY_W-1:ftlb_pkg::PAGE_W];
                    n_state     = ST_IDLE;
                end else if (r_left == '0) begin
                    n_m_valid = 1'b1;
                    n_m_hit   = 1'b0;
                    n_m_frame = '0;
                    n_state   = ST_IDLE;
                end else begin
                    n_ptr  = wrap_inc(r_ptr);
                    n_left = r_left - 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_head         <= '0;
            r_tail         <= '0;
            r_count        <= '0;
            r_hit_total    <= '0;
            r_lookup_total <= '0;
            r_m_valid      <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_head         <= n_head;
            r_tail         <= n_tail;
            r_count        <= n_count;
            r_hit_total    <= n_hit_total;
            r_lookup_total <= n_lookup_total;
            r_m_valid      <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr     <= n_ptr;
        r_left    <= n_left;
        r_page    <= n_page;
        r_m_hit   <= n_m_hit;
        r_m_frame <= n_m_frame;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_m_hit;
    assign o_m_tdata  = {ftlb_pkg::OCC_W'(r_count), r_lookup_total, r_hit_total, r_m_frame};

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Testbench for fifo_tlb_lookup_insert: sends lookups and inserts over the stream ports
// and checks each result against a FIFO-replacement TLB predictor kept here.
// Depends on ftlb_pkg and the TLB RTL.

module testbench;
    import ftlb_pkg::*;

    localparam int TLB_ENTRIES = 8;
    localparam int MAX_REPORTS = 10;
    localparam int TAIL_CYCLES = 4 * TLB_ENTRIES + 8;
    localparam int POOL_DEPTH  = 24;

    typedef struct {
        logic             hit;
        t_frame           frame;
        t_total           hits;
        t_total           lookups;
        logic [OCC_W-1:0] occ;
    } tlb_result_t;

    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // [31:0] virt_addr, [51:32] frame_in, [55:52] zero
    logic [S_DATA_W-1:0] s_tdata  = '0;
    // [0] req_type
    logic                s_tuser  = REQ_LOOKUP;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // [19:0] frame_out, [51:20] hit_count, [83:52] lookup_count, [87:84] occupancy
    logic [M_DATA_W-1:0] m_tdata;
    // [0] hit
    logic                m_tuser;

    // predicted table, index 0 oldest
    t_page       tag_fifo[$];
    t_frame      frame_fifo[$];
    t_total      hit_total;
    t_total      lookup_total;
    t_page       recent_pages[$];
    tlb_result_t pending_results[$];

    bit idle_on = 1'b1;
    int errors = 0;
    int n_lookups = 0;
    int n_hits = 0;
    int n_inserts = 0;
    int n_evictions = 0;

    always #1 i_clk = ~i_clk;

    fifo_tlb_lookup_insert #(.ENTRIES(TLB_ENTRIES)) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tuser  (m_tuser)
    );

    function automatic tlb_result_t translate(input logic kind, input logic [ADDR_W-1:0] vaddr,
                                              input t_frame frame);
        tlb_result_t r;
        t_page       page;
        page = vaddr[ADDR_W-1:PAGE_LSB];
        r.hit = 1'b0;
        r.frame = '0;
        if (kind == REQ_LOOKUP) begin
            lookup_total = lookup_total + 1;
            n_lookups++;
            foreach (tag_fifo[i]) begin
                if (!r.hit && tag_fifo[i] == page) begin
                    r.hit = 1'b1;
                    r.frame = frame_fifo[i];
                end
            end
            if (r.hit) begin
                hit_total = hit_total + 1;
                n_hits++;
            end
        end else begin
            n_inserts++;
            if (tag_fifo.size() == TLB_ENTRIES) begin
                void'(tag_fifo.pop_front());
                void'(frame_fifo.pop_front());
                n_evictions++;
            end
            tag_fifo.push_back(page);
            frame_fifo.push_back(frame);
            recent_pages.push_back(page);
            if (recent_pages.size() > POOL_DEPTH)
                void'(recent_pages.pop_front());
        end
        r.hits = hit_total;
        r.lookups = lookup_total;
        r.occ = OCC_W'(tag_fifo.size());
        return r;
    endfunction

    function automatic void note_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("ERROR @%0t: %s", $time, msg);
    endfunction

    task automatic send_item(input logic kind, input logic [ADDR_W-1:0] vaddr,
                             input t_frame frame);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_tvalid = 1'b1;
        s_tuser = kind;
        s_tdata = {{(S_DATA_W - ADDR_W - FRAME_W){1'b0}}, frame, vaddr};
        do @(posedge i_clk); while (s_tready !== 1'b1);
        pending_results.push_back(translate(kind, vaddr, frame));
    endtask

    task automatic lookup(input t_page page, input logic [PAGE_LSB-1:0] offset);
        send_item(REQ_LOOKUP, {page, offset}, t_frame'($urandom));
    endtask

    task automatic insert(input t_page page, input logic [PAGE_LSB-1:0] offset,
                          input t_frame frame);
        send_item(REQ_INSERT, {page, offset}, frame);
    endtask

    // hold the sender off until every outstanding transfer has come back
    task automatic wait_drained();
        @(negedge i_clk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_empty_table();
        send_item(REQ_LOOKUP, 32'h0000_0000, 20'hFFFFF);
        send_item(REQ_LOOKUP, 32'hFFFF_FFFF, 20'h00000);
        wait_drained();
    endtask

    task automatic test_fill_and_hit();
        insert(20'h00000, 12'hFFF, 20'hFFFFF);
        insert(20'hFFFFF, 12'h000, 20'h00000);
        for (int k = 1; k <= 6; k++)
            insert(t_page'(k * 20'h11111), 12'($urandom), t_frame'($urandom));
        lookup(20'hFFFFF, 12'hFFF);
        lookup(20'h00000, 12'h000);
        lookup(20'h44444, 12'h5A5);
        lookup(20'h7FFFF, 12'h800);
        wait_drained();
    endtask

    task automatic test_fifo_eviction();
        insert(20'h12345, 12'h678, 20'hABCDE);
        lookup(20'h00000, 12'h123);
        lookup(20'h12345, 12'hFFF);
        wait_drained();
    endtask

    // a repeated page must resolve to its oldest copy
    task automatic test_duplicate_pages();
        insert(20'h33333, 12'h001, 20'h55555);
        lookup(20'h33333, 12'hABC);
        lookup(20'hFFFFF, 12'h000);
        wait_drained();
    endtask

    task automatic test_random_traffic(input int count);
        int    insert_pct;
        int    pick;
        logic  kind;
        t_page page;
        insert_pct = 40;
        for (int n = 0; n < count; n++) begin
            if (n % 100 == 0) begin
                idle_on = ($urandom_range(0, 3) != 0);
                insert_pct = $urandom_range(15, 65);
            end
            if (n % 400 == 399)
                wait_drained();
            kind = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_LOOKUP;
            pick = $urandom_range(0, 99);
            page = t_page'($urandom);
            if (kind == REQ_INSERT) begin
                if (pick < 30 && recent_pages.size() > 0)
                    page = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
                insert(page, 12'($urandom), t_frame'($urandom));
            end else begin
                if (pick < 60 && tag_fifo.size() > 0)
                    page = tag_fifo[$urandom_range(0, tag_fifo.size() - 1)];
                else if (pick < 80 && recent_pages.size() > 0)
                    page = recent_pages[$urandom_range(0, recent_pages.size() - 1)];
                lookup(page, 12'($urandom));
            end
        end
    endtask

    // result side: random stalls, compare each transfer with the oldest prediction
    initial begin
        int          stall;
        tlb_result_t want;
        tlb_result_t got;
        forever begin
            stall = idle_on ? $urandom_range(0, 4) : 0;
            @(negedge i_clk);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_tready = 1'b1;
            do @(posedge i_clk); while (m_tvalid !== 1'b1);
            got.hit = m_tuser;
            got.frame = m_tdata[0 +: FRAME_W];
            got.hits = m_tdata[FRAME_W +: TOTAL_W];
            got.lookups = m_tdata[FRAME_W + TOTAL_W +: TOTAL_W];
            got.occ = m_tdata[FRAME_W + 2 * TOTAL_W +: OCC_W];
            if (pending_results.size() == 0) begin
                note_error($sformatf("unexpected result hit=%0b frame=%05h", got.hit, got.frame));
            end else begin
                want = pending_results.pop_front();
                if (got.hit !== want.hit || got.frame !== want.frame || got.hits !== want.hits
                        || got.lookups !== want.lookups || got.occ !== want.occ)
                    note_error($sformatf(
                        "exp hit=%0b frame=%05h hits=%0d lookups=%0d occ=%0d, got %0b %05h %0d %0d %0d",
                        want.hit, want.frame, want.hits, want.lookups, want.occ,
                        got.hit, got.frame, got.hits, got.lookups, got.occ));
            end
        end
    end

    initial begin
        #400000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        hit_total = '0;
        lookup_total = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_fill_and_hit();
        test_fifo_eviction();
        test_duplicate_pages();
        test_random_traffic(1850);

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Covered %0d lookups (%0d hits) and %0d inserts (%0d evictions).",
                 n_lookups, n_hits, n_inserts, n_evictions);
        $display("Mismatches: %0d", errors);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
